[src/chdu_pkg.sv]
// ----------------------------------------------------------------------------
// chdu_pkg
// Types, register indexes, constants and small helpers shared by the cohesive
// hinge damage update block.
// ----------------------------------------------------------------------------
package chdu_pkg;

	localparam int WORD_W    = 32;
	localparam int MAG_W     = 31;
	localparam int FRAC_BITS = 16;
	localparam int DMG_W     = 17;
	localparam int MUL_W     = 33;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int DIV_W     = 64;
	localparam int CNT_W     = 6;
	localparam int ADDR_W    = 5;
	localparam int KIND_W    = 2;
	localparam int IDX_W     = 3;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [MAG_W-1:0]  mag_t;
	typedef logic [KIND_W-1:0] kind_t;

	localparam kind_t KIND_TRIAL   = 2'd0;
	localparam kind_t KIND_COMMIT  = 2'd1;
	localparam kind_t KIND_REVERT  = 2'd2;
	localparam kind_t KIND_RESTART = 2'd3;

	localparam logic [IDX_W-1:0] REG_MOMENT_CAPACITY   = 3'd0;
	localparam logic [IDX_W-1:0] REG_PENALTY_STIFFNESS = 3'd1;
	localparam logic [IDX_W-1:0] REG_ACTIVATION_JUMP   = 3'd2;
	localparam logic [IDX_W-1:0] REG_SOFTENING_RATE    = 3'd3;
	localparam logic [IDX_W-1:0] REG_SOFTENING_SPAN    = 3'd4;
	localparam logic [IDX_W-1:0] REG_LINEAR_MODE       = 3'd5;

	localparam mag_t        Q16_ONE  = 31'd65536;
	localparam mag_t        MAG_MAX  = 31'h7fff_ffff;
	localparam logic [30:0] L2E_Q30  = 31'd1549082005;
	localparam logic [29:0] LN2_Q30  = 30'd744261118;
	localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
	localparam logic [3:0]  SERIES_K = 4'd10;

	typedef struct packed {
		mag_t moment_capacity;
		mag_t penalty_stiffness;
		mag_t activation_jump;
		mag_t softening_rate;
		mag_t softening_span;
		logic linear_mode;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] num;
		mag_t             den;
		logic [CNT_W-1:0] count;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quot;
	} div_rsp_t;

	// ceil(2^31 / k) for the series divisors
	function automatic logic [31:0] recip_q31(input logic [3:0] k);
		logic [31:0] r;
		case (k)
			4'd1:    r = 32'd2147483648;
			4'd2:    r = 32'd1073741824;
			4'd3:    r = 32'd715827883;
			4'd4:    r = 32'd536870912;
			4'd5:    r = 32'd429496730;
			4'd6:    r = 32'd357913942;
			4'd7:    r = 32'd306783379;
			4'd8:    r = 32'd268435456;
			4'd9:    r = 32'd238609295;
			4'd10:   r = 32'd214748365;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	function automatic mag_t sat_mag(input logic [63:0] v);
		return (v > {33'd0, MAG_MAX}) ? MAG_MAX : v[MAG_W-1:0];
	endfunction

	// negate a slope magnitude, clamped at 2^31
	function automatic word_t neg_slope(input logic [63:0] s);
		word_t c;
		c = (s > 64'h8000_0000) ? 32'h8000_0000 : s[WORD_W-1:0];
		return word_t'(~c + 32'd1);
	endfunction

endpackage

[src/chdu_if.sv]
// ----------------------------------------------------------------------------
// chdu_in_if / chdu_out_if
// Valid/ready channels carrying hinge events and hinge results.
// ----------------------------------------------------------------------------
interface chdu_in_if;
	import chdu_pkg::*;
	logic  valid;
	logic  ready;
	kind_t kind;
	logic signed [WORD_W-1:0] jump;

	modport source (output valid, output kind, output jump, input ready);
	modport sink (input valid, input kind, input jump, output ready);
endinterface

interface chdu_out_if;
	import chdu_pkg::*;
	logic valid;
	logic ready;
	logic signed [WORD_W-1:0] moment;
	logic signed [WORD_W-1:0] tangent;
	mag_t max_jump;
	logic signed [WORD_W-1:0] work;
	logic [DMG_W-1:0] damage;
	logic fully_open;

	modport source (output valid, output moment, output tangent, output max_jump,
		output work, output damage, output fully_open, input ready);
	modport sink (input valid, input moment, input tangent, input max_jump,
		input work, input damage, input fully_open, output ready);
endinterface

[src/chdu_regs.sv]
// ----------------------------------------------------------------------------
// chdu_regs
// APB-style register bank holding the hinge calibration.
// ----------------------------------------------------------------------------
module chdu_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [chdu_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output chdu_pkg::cfg_t             cfg
);
	import chdu_pkg::*;

	logic [IDX_W-1:0] idx;
	logic             wr;
	cfg_t             cfg_q;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.moment_capacity   <= Q16_ONE;
			cfg_q.penalty_stiffness <= Q16_ONE;
			cfg_q.activation_jump   <= Q16_ONE;
			cfg_q.softening_rate    <= Q16_ONE;
			cfg_q.softening_span    <= Q16_ONE;
			cfg_q.linear_mode       <= 1'b0;
		end else if (wr) begin
			case (idx)
				REG_MOMENT_CAPACITY:   cfg_q.moment_capacity   <= pwdata[MAG_W-1:0];
				REG_PENALTY_STIFFNESS: cfg_q.penalty_stiffness <= pwdata[MAG_W-1:0];
				REG_ACTIVATION_JUMP:   cfg_q.activation_jump   <= pwdata[MAG_W-1:0];
				REG_SOFTENING_RATE:    cfg_q.softening_rate    <= pwdata[MAG_W-1:0];
				REG_SOFTENING_SPAN:    cfg_q.softening_span    <= pwdata[MAG_W-1:0];
				REG_LINEAR_MODE:       cfg_q.linear_mode       <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MOMENT_CAPACITY:   prdata = {1'b0, cfg_q.moment_capacity};
			REG_PENALTY_STIFFNESS: prdata = {1'b0, cfg_q.penalty_stiffness};
			REG_ACTIVATION_JUMP:   prdata = {1'b0, cfg_q.activation_jump};
			REG_SOFTENING_RATE:    prdata = {1'b0, cfg_q.softening_rate};
			REG_SOFTENING_SPAN:    prdata = {1'b0, cfg_q.softening_span};
			REG_LINEAR_MODE:       prdata = {31'd0, cfg_q.linear_mode};
			default:               prdata = 32'd0;
		endcase
	end

endmodule

[src/chdu_mul.sv]
// ----------------------------------------------------------------------------
// chdu_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module chdu_mul (
	input  logic                        clk,
	input  logic [chdu_pkg::MUL_W-1:0]  a,
	input  logic [chdu_pkg::MUL_W-1:0]  b,
	output logic [chdu_pkg::PROD_W-1:0] p
);
	import chdu_pkg::*;

	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

[src/chdu_div.sv]
// ----------------------------------------------------------------------------
// chdu_div
// Restoring divider, one quotient bit a cycle. The numerator arrives left
// aligned; count gives the number of quotient bits.
// ----------------------------------------------------------------------------
module chdu_div (
	input  logic               clk,
	input  logic               arst_n,
	input  chdu_pkg::div_req_t req,
	output chdu_pkg::div_rsp_t rsp
);
	import chdu_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] nq_q;
	mag_t             rem_q;
	mag_t             den_q;
	logic [MAG_W:0]   trial;
	logic [MAG_W:0]   diff;
	logic             fit;

	assign trial = {rem_q, nq_q[DIV_W-1]};
	assign fit   = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = nq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.count;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in at the bottom as the numerator leaves the top
	always_ff @(posedge clk) begin
		if (req.start) begin
			nq_q  <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			nq_q  <= {nq_q[DIV_W-2:0], fit};
			rem_q <= fit ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
		end
	end

endmodule

[src/cohesive_hinge_damage_update_top.sv]
// ----------------------------------------------------------------------------
// cohesive_hinge_damage_update_top
// Cohesive moment-rotation hinge with irreversible damage, Q16.16.
//
// Usage:
//   item   : event word (kind, jump). kind 0 is a trial jump, 1 commits the
//            trial state, 2 reverts to the committed state, 3 clears all.
//   result : one word per event with the trial moment, tangent, maximum
//            jump, path work, damage and fully-open flag after the event.
//   APB    : calibration registers, to be written only while no event is in
//            flight; the block itself does not enforce this.
// The serial divider sets most of the time from acceptance to result, at one
//   quotient bit a cycle, 47 or 62 bits, with up to four divisions per event
//   in linear mode; exponential mode adds a ten-term series on the multiplier.
// Throughput: one event at a time; item.ready is high only between events.
//   The next event may be taken while the previous result still waits.
// Reset: clears all history and restores the default calibration; the
//   trial tangent returns to the penalty stiffness.
// Stall: a finished result is held in the output register until taken; the
//   next event then waits in its final step until the register frees.
// ----------------------------------------------------------------------------
module cohesive_hinge_damage_update_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [chdu_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	chdu_in_if.sink                     item,
	chdu_out_if.source                  result
);
	import chdu_pkg::*;

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_ENV  = 5'd1;
	localparam logic [4:0] ST_PRE  = 5'd2;
	localparam logic [4:0] ST_LIN1 = 5'd3;
	localparam logic [4:0] ST_LIN2 = 5'd4;
	localparam logic [4:0] ST_LIN3 = 5'd5;
	localparam logic [4:0] ST_EX0  = 5'd6;
	localparam logic [4:0] ST_EX1  = 5'd7;
	localparam logic [4:0] ST_EX2  = 5'd8;
	localparam logic [4:0] ST_HM   = 5'd9;
	localparam logic [4:0] ST_HD   = 5'd10;
	localparam logic [4:0] ST_HC   = 5'd11;
	localparam logic [4:0] ST_EXF  = 5'd12;
	localparam logic [4:0] ST_EXM  = 5'd13;
	localparam logic [4:0] ST_EXM1 = 5'd14;
	localparam logic [4:0] ST_EXM2 = 5'd15;
	localparam logic [4:0] ST_EXM3 = 5'd16;
	localparam logic [4:0] ST_SEC  = 5'd17;
	localparam logic [4:0] ST_SEC1 = 5'd18;
	localparam logic [4:0] ST_SECD = 5'd19;
	localparam logic [4:0] ST_MOM  = 5'd20;
	localparam logic [4:0] ST_MOM1 = 5'd21;
	localparam logic [4:0] ST_MOM2 = 5'd22;
	localparam logic [4:0] ST_MOM3 = 5'd23;
	localparam logic [4:0] ST_MOM4 = 5'd24;
	localparam logic [4:0] ST_DMG  = 5'd25;
	localparam logic [4:0] ST_DMG1 = 5'd26;
	localparam logic [4:0] ST_FIN  = 5'd27;

	cfg_t     cfg;
	div_req_t div_req;
	div_rsp_t div_rsp;

	logic [MUL_W-1:0]  mul_a;
	logic [MUL_W-1:0]  mul_b;
	logic [PROD_W-1:0] prod;

	logic [4:0] state_q;

	// history
	mag_t  cmj_q, tmj_q;
	word_t cj_q, cm_q, cw_q;
	word_t tj_q, tm_q, tt_q, tw_q;

	// working registers
	kind_t             kind_q;
	word_t             jump_q;
	word_t             jmag_q;
	logic              loading_q;
	logic              nonzero_q;
	mag_t              km_q;
	mag_t              m_q;
	word_t             dm_q;
	mag_t              ks_q;
	logic [21:0]       x_q;
	logic [4:0]        n_q;
	logic [30:0]       r_q;
	logic [30:0]       e_q;
	logic [29:0]       p_q;
	logic [3:0]        k_q;
	logic [DMG_W-1:0]  e16_q;
	logic [MUL_W-1:0]  sa_q;
	logic [MUL_W-1:0]  da_q;
	logic              wneg_q;
	logic [DMG_W-1:0]  dmg_q;

	logic              out_valid_q;
	word_t             out_moment_q, out_tangent_q, out_work_q;
	mag_t              out_max_jump_q;
	logic [DMG_W-1:0]  out_damage_q;
	logic              out_open_q;

	// combinational helpers
	word_t             in_mag;
	mag_t              in_abs;
	logic              in_loading;
	logic              above_k0;
	mag_t              soft_d;
	logic              n_big;
	logic [36:0]       rem_s;
	logic [29:0]       q0;
	logic [33:0]       q0k;
	logic [29:0]       q_fix;
	logic [30:0]       e_sh;
	mag_t              mm;
	word_t             tm_new;
	logic [32:0]       s_sum;
	logic [32:0]       dj_sum;
	logic [48:0]       sm;
	logic signed [50:0] inc_s;
	logic signed [50:0] w_sum;
	word_t             w_sat;
	logic              fin_load;
	logic [WORD_W-1:0] open_lim;

	chdu_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	chdu_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	chdu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_mag     = item.jump[WORD_W-1] ? word_t'(32'd0 - item.jump) : item.jump;
	assign in_abs     = in_mag[WORD_W-1] ? MAG_MAX : in_mag[MAG_W-1:0];
	assign in_loading = in_abs >= cmj_q;

	assign above_k0 = km_q > cfg.activation_jump;
	assign soft_d   = km_q - cfg.activation_jump;
	assign n_big    = prod[52:46] >= 7'd31;
	assign rem_s    = {1'b0, x_q, 14'd0} - {2'd0, prod[34:0]};
	assign q0       = prod[60:31];
	assign q0k      = {4'd0, q0} * {30'd0, k_q};
	assign q_fix    = (q0k > {4'd0, p_q}) ? q0 - 30'd1 : q0;
	assign e_sh     = e_q >> n_q;
	assign mm       = sat_mag(64'(prod[PROD_W-1:FRAC_BITS]));
	assign tm_new   = jump_q[WORD_W-1] ? word_t'(32'd0 - {1'b0, mm}) : {1'b0, mm};
	assign s_sum    = {cm_q[31], cm_q} + {tm_q[31], tm_q};
	assign dj_sum   = {tj_q[31], tj_q} - {cj_q[31], cj_q};
	assign sm       = prod[65:17];
	assign inc_s    = wneg_q ? -$signed({2'b00, sm}) : $signed({2'b00, sm});
	assign w_sum    = $signed({{19{cw_q[31]}}, cw_q}) + inc_s;
	assign w_sat    = (w_sum > 51'sd2147483647) ? 32'h7fff_ffff :
		(w_sum < -51'sd2147483648) ? 32'h8000_0000 : w_sum[WORD_W-1:0];
	assign fin_load = (state_q == ST_FIN) && (!out_valid_q || result.ready);
	assign open_lim = {1'b0, cfg.activation_jump} + {1'b0, cfg.softening_span};

	// operand selection for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_ENV: begin
				if (!above_k0) begin
					mul_a = MUL_W'(cfg.penalty_stiffness);
					mul_b = MUL_W'(km_q);
				end else if (cfg.linear_mode) begin
					mul_a = MUL_W'(cfg.moment_capacity);
					mul_b = MUL_W'(cfg.softening_span - soft_d);
				end else begin
					mul_a = MUL_W'(cfg.softening_rate);
					mul_b = MUL_W'(soft_d);
				end
			end
			ST_EX0: begin
				mul_a = MUL_W'(prod[37:16]);
				mul_b = MUL_W'(L2E_Q30);
			end
			ST_EX1: begin
				mul_a = MUL_W'(prod[50:46]);
				mul_b = MUL_W'(LN2_Q30);
			end
			ST_HM: begin
				mul_a = MUL_W'(r_q);
				mul_b = MUL_W'(e_q);
			end
			ST_HD: begin
				mul_a = MUL_W'(prod[59:30]);
				mul_b = MUL_W'(recip_q31(k_q));
			end
			ST_EXM: begin
				mul_a = MUL_W'(cfg.moment_capacity);
				mul_b = MUL_W'(e16_q);
			end
			ST_EXM2: begin
				mul_a = MUL_W'(cfg.softening_rate);
				mul_b = MUL_W'(m_q);
			end
			ST_MOM: begin
				mul_a = MUL_W'(jmag_q);
				mul_b = MUL_W'(ks_q);
			end
			ST_MOM3: begin
				mul_a = sa_q;
				mul_b = da_q;
			end
			default: ;
		endcase
	end

	// divider requests; numerators are left aligned in the 64-bit word
	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = '0;
		div_req.den   = cfg.softening_span;
		div_req.count = CNT_W'(47);
		case (state_q)
			ST_LIN1: begin
				div_req.start = 1'b1;
				div_req.num   = {prod[61:0], 2'b00};
				div_req.count = CNT_W'(62);
			end
			ST_LIN2: begin
				div_req.start = div_rsp.done;
				div_req.num   = {cfg.moment_capacity, 33'd0};
			end
			ST_SEC: begin
				div_req.start = km_q != '0;
				div_req.num   = {m_q, 33'd0};
				div_req.den   = km_q;
			end
			ST_DMG: begin
				div_req.start = cfg.penalty_stiffness != '0;
				div_req.num   = {ks_q, 33'd0};
				div_req.den   = cfg.penalty_stiffness;
			end
			default: ;
		endcase
	end

	// sequencer and hinge history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmj_q       <= '0;
			cj_q        <= '0;
			cm_q        <= '0;
			cw_q        <= '0;
			tmj_q       <= '0;
			tj_q        <= '0;
			tm_q        <= '0;
			tt_q        <= {1'b0, Q16_ONE};
			tw_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: if (item.valid) begin
					state_q <= ST_ENV;
					case (item.kind)
						KIND_COMMIT: begin
							cmj_q <= tmj_q;
							cj_q  <= tj_q;
							cm_q  <= tm_q;
							cw_q  <= tw_q;
						end
						KIND_REVERT: begin
							tmj_q <= cmj_q;
							tj_q  <= cj_q;
							tm_q  <= cm_q;
							tw_q  <= cw_q;
						end
						KIND_RESTART: begin
							cmj_q <= '0;
							cj_q  <= '0;
							cm_q  <= '0;
							cw_q  <= '0;
							tmj_q <= '0;
							tj_q  <= '0;
							tm_q  <= '0;
							tw_q  <= '0;
							tt_q  <= {1'b0, cfg.penalty_stiffness};
						end
						default: ;
					endcase
				end
				ST_ENV: begin
					if (!above_k0) begin
						state_q <= ST_PRE;
					end else if (cfg.linear_mode) begin
						state_q <= (soft_d >= cfg.softening_span) ? ST_SEC : ST_LIN1;
					end else begin
						state_q <= ST_EX0;
					end
				end
				ST_PRE:  state_q <= ST_SEC;
				ST_LIN1: state_q <= ST_LIN2;
				ST_LIN2: if (div_rsp.done) begin
					state_q <= ST_LIN3;
				end
				ST_LIN3: if (div_rsp.done) begin
					state_q <= ST_SEC;
				end
				ST_EX0:  state_q <= (prod[61:38] != '0) ? ST_EXM : ST_EX1;
				ST_EX1:  state_q <= n_big ? ST_EXM : ST_EX2;
				ST_EX2:  state_q <= ST_HM;
				ST_HM:   state_q <= ST_HD;
				ST_HD:   state_q <= ST_HC;
				ST_HC:   state_q <= (k_q == 4'd1) ? ST_EXF : ST_HM;
				ST_EXF:  state_q <= ST_EXM;
				ST_EXM:  state_q <= ST_EXM1;
				ST_EXM1: state_q <= ST_EXM2;
				ST_EXM2: state_q <= ST_EXM3;
				ST_EXM3: state_q <= ST_SEC;
				ST_SEC:  state_q <= (km_q == '0) ? ST_SECD : ST_SEC1;
				ST_SEC1: if (div_rsp.done) begin
					state_q <= ST_SECD;
				end
				ST_SECD: begin
					if (kind_q == KIND_TRIAL) begin
						state_q <= ST_MOM;
					end else begin
						state_q <= ST_DMG;
					end
					if (kind_q == KIND_REVERT) begin
						tt_q <= {1'b0, ks_q};
					end
				end
				ST_MOM: state_q <= ST_MOM1;
				ST_MOM1: begin
					state_q <= ST_MOM2;
					tm_q    <= tm_new;
					tt_q    <= (loading_q && nonzero_q) ? dm_q : {1'b0, ks_q};
					tmj_q   <= km_q;
					tj_q    <= jump_q;
				end
				ST_MOM2: state_q <= ST_MOM3;
				ST_MOM3: state_q <= ST_MOM4;
				ST_MOM4: begin
					state_q <= ST_DMG;
					tw_q    <= w_sat;
				end
				ST_DMG: state_q <= (cfg.penalty_stiffness == '0) ? ST_FIN : ST_DMG1;
				ST_DMG1: if (div_rsp.done) begin
					state_q <= ST_FIN;
				end
				ST_FIN: if (fin_load) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working values
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (item.valid) begin
				kind_q    <= item.kind;
				jump_q    <= item.jump;
				jmag_q    <= in_mag;
				loading_q <= in_loading;
				nonzero_q <= in_abs != '0;
				case (item.kind)
					KIND_TRIAL:  km_q <= in_loading ? in_abs : cmj_q;
					KIND_COMMIT: km_q <= tmj_q;
					KIND_REVERT: km_q <= cmj_q;
					default:     km_q <= '0;
				endcase
			end
			ST_ENV: begin
				// fully broken: no moment and no slope
				m_q  <= '0;
				dm_q <= '0;
			end
			ST_PRE: begin
				m_q  <= sat_mag(64'(prod[PROD_W-1:FRAC_BITS]));
				dm_q <= {1'b0, cfg.penalty_stiffness};
			end
			ST_LIN2: if (div_rsp.done) begin
				m_q <= div_rsp.quot[MAG_W-1:0];
			end
			ST_LIN3: if (div_rsp.done) begin
				dm_q <= neg_slope(div_rsp.quot);
			end
			ST_EX0: begin
				x_q   <= prod[37:16];
				e16_q <= '0;
			end
			ST_EX1: begin
				n_q   <= prod[50:46];
				e16_q <= '0;
			end
			ST_EX2: begin
				r_q <= rem_s[36] ? 31'd0 : rem_s[30:0];
				e_q <= Q30_ONE;
				k_q <= SERIES_K;
			end
			ST_HD: p_q <= prod[59:30];
			ST_HC: begin
				e_q <= Q30_ONE - {1'b0, q_fix};
				k_q <= k_q - 4'd1;
			end
			ST_EXF: e16_q <= DMG_W'((e_sh + 31'd8192) >> 14);
			ST_EXM1: m_q <= prod[46:16];
			ST_EXM3: dm_q <= neg_slope(64'(prod[PROD_W-1:FRAC_BITS]));
			ST_SEC: if (km_q == '0) begin
				ks_q <= cfg.penalty_stiffness;
			end
			ST_SEC1: if (div_rsp.done) begin
				ks_q <= sat_mag(div_rsp.quot);
			end
			ST_MOM2: begin
				sa_q   <= s_sum[32] ? 33'd0 - s_sum : s_sum;
				da_q   <= dj_sum[32] ? 33'd0 - dj_sum : dj_sum;
				wneg_q <= s_sum[32] ^ dj_sum[32];
			end
			ST_DMG: dmg_q <= '0;
			ST_DMG1: if (div_rsp.done) begin
				dmg_q <= (div_rsp.quot[DIV_W-1:16] != '0) ? '0 :
					DMG_W'(17'h1_0000 - {1'b0, div_rsp.quot[15:0]});
			end
			default: ;
		endcase
		if (fin_load) begin
			out_moment_q   <= tm_q;
			out_tangent_q  <= tt_q;
			out_max_jump_q <= tmj_q;
			out_work_q     <= tw_q;
			out_damage_q   <= dmg_q;
			out_open_q     <= cfg.linear_mode && ({1'b0, tmj_q} >= open_lim);
		end
	end

	assign item.ready        = state_q == ST_IDLE;
	assign result.valid      = out_valid_q;
	assign result.moment     = out_moment_q;
	assign result.tangent    = out_tangent_q;
	assign result.max_jump   = out_max_jump_q;
	assign result.work       = out_work_q;
	assign result.damage     = out_damage_q;
	assign result.fully_open = out_open_q;

`ifndef SYNTH
	a_div_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_series_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HM || state_q == ST_HD || state_q == ST_HC)
		|-> (k_q >= 4'd1 && k_q <= SERIES_K))
		else $error("series term counter out of range");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> state_q != ST_IDLE)
		else $error("event accepted but sequencer idle");

	a_intact_no_damage: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.max_jump == '0) |-> result.damage == '0)
		else $error("damage reported on an unopened hinge");
`endif

endmodule

[dv/cohesive_hinge_damage_update_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cohesive_hinge_damage_update_top_tb
// Drives hinge events through the valid/ready item channel and checks every
// result word against a cycle-free bench model of the hinge or a typed word.
// Calibration is reloaded over APB between phases, including its extremes.
// ----------------------------------------------------------------------------
module cohesive_hinge_damage_update_top_tb;
	import chdu_pkg::*;

	localparam logic [63:0] WORD_MAX = 64'h7fff_ffff;

	typedef struct {
		logic [31:0] moment;
		logic [31:0] tangent;
		logic [30:0] max_jump;
		logic [31:0] work;
		logic [16:0] damage;
		logic        fully_open;
	} hinge_out_t;

	typedef struct {
		kind_t       kind;
		logic [31:0] jump;
		logic        typed;
		hinge_out_t  want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	chdu_in_if  item_ch ();
	chdu_out_if result_ch ();

	cohesive_hinge_damage_update_top u_top (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready), .item(item_ch.sink), .result(result_ch.source)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// calibration and history copy
	logic [63:0] cap, pen, act, rate, span;
	logic        lin;
	logic [63:0] c_max, t_max;
	longint      c_jump, c_mom, c_work, t_jump, t_mom, t_tan, t_work;

	hinge_out_t expected_words[$];
	int  fail_count = 0;
	int  send_idle_pct = 0, recv_idle_pct = 0;
	bit  recv_hold = 1'b0;
	int  hold_cycles = 0;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	function automatic logic [63:0] sat31(input logic [63:0] v);
		return (v > WORD_MAX) ? WORD_MAX : v;
	endfunction

	function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
		return (a * b) >> 16;
	endfunction

	function automatic logic [63:0] magnitude(input longint v);
		return v < 0 ? 64'd0 - 64'(v) : 64'(v);
	endfunction

	function automatic logic [63:0] exp_decay(input logic [63:0] x);
		logic [63:0] n, r, e;
		longint rs;
		if (x >= (64'd64 << 16)) return 0;
		n = (x * 64'd1549082005) >> 46;
		if (n >= 31) return 0;
		rs = longint'(x << 14) - longint'(n * 64'd744261118);
		r = rs < 0 ? 64'd0 : 64'(rs);
		e = 64'd1 << 30;
		for (int k = 10; k >= 1; k--)
			e = (64'd1 << 30) - ((r * e) >> 30) / 64'(k);
		e >>= n;
		return (e + (64'd1 << 13)) >> 14;
	endfunction

	task automatic envelope_at(input logic [63:0] km, output logic [63:0] m, output longint dm);
		logic [63:0] d, s;
		if (km <= act) begin
			m = sat31(qmul(pen, km));
			dm = longint'(pen);
			return;
		end
		d = km - act;
		if (lin) begin
			if (d >= span) begin
				m = 0;
				dm = 0;
				return;
			end
			m = cap * (span - d) / span;
			s = (cap << 16) / span;
		end else begin
			m = qmul(cap, exp_decay(qmul(rate, d)));
			s = qmul(rate, m);
		end
		if (s > WORD_MAX + 1) s = WORD_MAX + 1;
		dm = -longint'(s);
	endtask

	function automatic logic [63:0] secant_at(input logic [63:0] km, input logic [63:0] m);
		if (km == 0) return pen;
		return sat31((m << 16) / km);
	endfunction

	task automatic clear_history();
		c_max = 0; t_max = 0;
		c_jump = 0; c_mom = 0; c_work = 0;
		t_jump = 0; t_mom = 0; t_work = 0;
		t_tan = longint'(pen);
	endtask

	task automatic hinge_update(input kind_t kind, input logic [31:0] jraw,
			output hinge_out_t o);
		logic [63:0] a, m, ks, mm, sm, q, dmg;
		longint dm, j, s, dj, inc, w;
		bit loading;
		case (kind)
			KIND_TRIAL: begin
				j = longint'($signed(jraw));
				a = sat31(magnitude(j));
				loading = a >= c_max;
				t_max = loading ? a : c_max;
				envelope_at(t_max, m, dm);
				ks = secant_at(t_max, m);
				mm = sat31(qmul(magnitude(j), ks));
				t_mom = j < 0 ? -longint'(mm) : longint'(mm);
				t_tan = (loading && a > 0) ? dm : longint'(ks);
				s = c_mom + t_mom;
				dj = j - c_jump;
				sm = (magnitude(s) * magnitude(dj)) >> 17;
				inc = longint'(sm);
				if ((s < 0) != (dj < 0)) inc = -inc;
				w = c_work + inc;
				if (w > longint'(WORD_MAX)) w = longint'(WORD_MAX);
				if (w < -longint'(WORD_MAX) - 1) w = -longint'(WORD_MAX) - 1;
				t_work = w;
				t_jump = j;
			end
			KIND_COMMIT: begin
				c_max = t_max; c_jump = t_jump; c_mom = t_mom; c_work = t_work;
			end
			KIND_REVERT: begin
				t_max = c_max; t_jump = c_jump; t_mom = c_mom; t_work = c_work;
				envelope_at(t_max, m, dm);
				t_tan = longint'(secant_at(t_max, m));
			end
			default: clear_history();
		endcase
		envelope_at(t_max, m, dm);
		ks = secant_at(t_max, m);
		dmg = 0;
		if (pen != 0) begin
			q = (ks << 16) / pen;
			dmg = q >= 64'h10000 ? 64'd0 : 64'h10000 - q;
		end
		o.moment = t_mom[31:0];
		o.tangent = t_tan[31:0];
		o.max_jump = t_max[30:0];
		o.work = t_work[31:0];
		o.damage = dmg[16:0];
		o.fully_open = lin && (t_max >= act + span);
	endtask

	task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [31:0] v);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= ADDR_W'(idx) << 2; pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_MOMENT_CAPACITY:   cap = 64'(v[30:0]);
			REG_PENALTY_STIFFNESS: pen = 64'(v[30:0]);
			REG_ACTIVATION_JUMP:   act = 64'(v[30:0]);
			REG_SOFTENING_RATE:    rate = 64'(v[30:0]);
			REG_SOFTENING_SPAN:    span = 64'(v[30:0]);
			default:               lin = v[0];
		endcase
	endtask

	task automatic load_calibration(input logic [31:0] c, input logic [31:0] k,
			input logic [31:0] k0, input logic [31:0] a, input logic [31:0] kf,
			input logic mode);
		cfg_write(REG_MOMENT_CAPACITY, c);
		cfg_write(REG_PENALTY_STIFFNESS, k);
		cfg_write(REG_ACTIVATION_JUMP, k0);
		cfg_write(REG_SOFTENING_RATE, a);
		cfg_write(REG_SOFTENING_SPAN, kf);
		cfg_write(REG_LINEAR_MODE, {31'd0, mode});
	endtask

	task automatic drain();
		while (expected_words.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	// one event; typed rows override the predicted word
	task automatic send_event(input kind_t kind, input logic [31:0] jump,
			input bit typed, input hinge_out_t want);
		hinge_out_t o;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.kind <= kind;
		item_ch.jump <= jump;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		hinge_update(kind, jump, o);
		expected_words.push_back(typed ? want : o);
		@(negedge clk);
		item_ch.valid <= 1'b0;
	endtask

	function automatic logic [31:0] rand_jump();
		case ($urandom_range(5))
			0: return $urandom();
			1: return 32'($signed($urandom_range(4 * 65536)) - 2 * 65536);
			2: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
			3: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom())};
			default: return 32'($signed($urandom_range(8 * 65536)) - 4 * 65536);
		endcase
	endfunction

	// mostly load-commit-revert cycles with random content
	task automatic random_phase(input int count);
		hinge_out_t none;
		kind_t kd;
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < 60) kd = KIND_TRIAL;
			else if (r < 80) kd = KIND_COMMIT;
			else if (r < 94) kd = KIND_REVERT;
			else kd = KIND_RESTART;
			send_event(kd, rand_jump(), 1'b0, none);
		end
	endtask

	// output side: receiver stall and checking
	always @(posedge clk) begin
		if (result_ch.valid && result_ch.ready) begin
			if (expected_words.size() == 0) begin
				report("unexpected word", 64'd0, 64'd0);
			end else begin
				hinge_out_t w;
				w = expected_words.pop_front();
				if (result_ch.moment !== w.moment)
					report("moment", 64'(result_ch.moment), 64'(w.moment));
				if (result_ch.tangent !== w.tangent)
					report("tangent", 64'(result_ch.tangent), 64'(w.tangent));
				if (result_ch.max_jump !== w.max_jump)
					report("max_jump", 64'(result_ch.max_jump), 64'(w.max_jump));
				if (result_ch.work !== w.work)
					report("work", 64'(result_ch.work), 64'(w.work));
				if (result_ch.damage !== w.damage)
					report("damage", 64'(result_ch.damage), 64'(w.damage));
				if (result_ch.fully_open !== w.fully_open)
					report("fully_open", 64'(result_ch.fully_open), 64'(w.fully_open));
			end
		end
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			result_ch.ready <= 1'b0;
		end else if (recv_hold) begin
			hold_cycles <= 1500;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		#4000000;
		$display("cohesive_hinge_damage_update_top_tb NOT OK");
		$finish;
	end

	initial begin
		stim_row_t rows[$];
		hinge_out_t z, none;
		item_ch.valid = 1'b0;
		item_ch.kind = KIND_TRIAL;
		item_ch.jump = '0;
		result_ch.ready = 1'b0;
		cap = 65536; pen = 65536; act = 65536; rate = 65536; span = 65536; lin = 1'b0;
		clear_history();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// after reset a commit shows the untouched history
		z = '{moment: 0, tangent: 32'd65536, max_jump: 0, work: 0, damage: 0, fully_open: 0};
		rows.push_back('{KIND_COMMIT, 32'd0, 1'b1, z});
		rows.push_back('{KIND_TRIAL, 32'd0, 1'b0, none});
		rows.push_back('{KIND_TRIAL, 32'h0000_8000, 1'b0, none});
		rows.push_back('{KIND_TRIAL, 32'h0001_0000, 1'b0, none});
		rows.push_back('{KIND_COMMIT, 32'd0, 1'b0, none});
		rows.push_back('{KIND_TRIAL, 32'h0000_4000, 1'b0, none});
		rows.push_back('{KIND_TRIAL, 32'hffff_0000, 1'b0, none});
		rows.push_back('{KIND_REVERT, 32'd0, 1'b0, none});
		rows.push_back('{KIND_TRIAL, 32'h0003_0000, 1'b0, none});
		rows.push_back('{KIND_TRIAL, 32'h7fff_ffff, 1'b0, none});
		rows.push_back('{KIND_TRIAL, 32'h8000_0000, 1'b0, none});
		rows.push_back('{KIND_COMMIT, 32'd0, 1'b0, none});
		rows.push_back('{KIND_TRIAL, 32'h0000_0001, 1'b0, none});
		rows.push_back('{KIND_REVERT, 32'hffff_ffff, 1'b0, none});
		rows.push_back('{KIND_RESTART, 32'hffff_ffff, 1'b1, z});
		rows.push_back('{KIND_TRIAL, 32'h8000_0000, 1'b0, none});
		rows.push_back('{KIND_RESTART, 32'd0, 1'b1, z});
		send_idle_pct = 6; recv_idle_pct = 82;
		foreach (rows[i]) send_event(rows[i].kind, rows[i].jump, rows[i].typed, rows[i].want);
		drain();

		random_phase(250);
		drain();

		// linear softening, including zero span and zero penalty
		load_calibration(32'h0002_0000, 32'h0004_0000, 32'h0000_8000, 32'h0001_0000,
			32'h0001_0000, 1'b1);
		send_event(KIND_RESTART, 0, 1'b0, none);
		random_phase(200);
		drain();
		load_calibration(32'h7fff_ffff, 32'd0, 32'h0001_0000, 32'h0000_0000, 32'd0, 1'b1);
		send_event(KIND_RESTART, 0, 1'b0, none);
		send_event(KIND_TRIAL, 32'h0002_0000, 1'b0, none);
		random_phase(100);
		drain();

		// swap idling sides
		send_idle_pct = 82; recv_idle_pct = 6;
		load_calibration(32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0100, 32'h7fff_ffff,
			32'h0000_0001, 1'b0);
		send_event(KIND_RESTART, 0, 1'b0, none);
		random_phase(200);
		drain();
		load_calibration(32'h0003_0000, 32'h0000_4000, 32'd0, 32'h0000_2000,
			32'h7fff_ffff, 1'b0);
		send_event(KIND_RESTART, 0, 1'b0, none);
		random_phase(200);
		drain();

		// no idling; long receiver hold while events keep coming
		send_idle_pct = 0; recv_idle_pct = 0;
		load_calibration($urandom() >> 8, $urandom() >> 10, $urandom() >> 12,
			$urandom() >> 12, $urandom() >> 12, 1'b1);
		send_event(KIND_RESTART, 0, 1'b0, none);
		recv_hold = 1'b1;
		wait (hold_cycles > 0);
		recv_hold = 1'b0;
		random_phase(4);
		random_phase(200);
		drain();
		load_calibration($urandom() >> 1, $urandom() >> 1, $urandom() >> 1,
			$urandom() >> 1, $urandom() >> 1, 1'b0);
		send_event(KIND_RESTART, 0, 1'b0, none);
		random_phase(280);
		drain();

		if (fail_count == 0)
			$display("cohesive_hinge_damage_update_top_tb OK");
		else
			$display("cohesive_hinge_damage_update_top_tb NOT OK");
		$finish;
	end

endmodule
